// File: hw/rtl/k_stacks_shared_array_defines.svh
// Assertion helpers used by kss_back.sv.
`ifndef K_STACKS_SHARED_ARRAY_DEFINES_SVH
`define K_STACKS_SHARED_ARRAY_DEFINES_SVH

// Same-cycle implication, checked at every edge outside reset.
`define KSS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kss assertion failed");

// Next-cycle implication, checked at every edge outside reset.
`define KSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kss assertion failed");

`endif

// File: hw/rtl/kss_pkg.sv
package kss_pkg;

  localparam int SID_W    = 2;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

  // Decoded operation handed from the front queue to the engine.
  typedef struct packed {
    logic             is_pop;
    logic             sid_ok;
    logic [SID_W-1:0] sid;
    logic [VAL_W-1:0] value;
  } cmd_t;

endpackage

// File: hw/rtl/kss_front.sv
module kss_front
  import kss_pkg::*;
#(
  parameter int NUM_STACKS = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  logic             in_mode,
  input  logic [SID_W-1:0] in_stack_id,
  input  logic [VAL_W-1:0] in_push_value,
  output logic             cmd_vld,
  input  logic             cmd_take,
  output cmd_t             cmd
);

  cmd_t       q_r [2];
  logic       wptr_r;
  logic       rptr_r;
  logic [1:0] cnt_r;
  logic       wr_en;
  logic       rd_en;
  cmd_t       cmd_in;

  assign in_full = (cnt_r == 2'd2);
  assign cmd_vld = (cnt_r != 2'd0);
  assign wr_en   = in_push && !in_full;
  assign rd_en   = cmd_take && cmd_vld;
  assign cmd     = q_r[rptr_r];

  always_comb begin
    cmd_in.is_pop = (in_mode == MODE_POP);
    cmd_in.sid_ok = (32'(in_stack_id) < NUM_STACKS);
    cmd_in.sid    = in_stack_id;
    cmd_in.value  = in_push_value;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wptr_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (wr_en) begin
        wptr_r <= ~wptr_r;
      end
      if (rd_en) begin
        rptr_r <= ~rptr_r;
      end
      case ({wr_en, rd_en})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// File: hw/rtl/kss_back.sv
`include "k_stacks_shared_array_defines.svh"

module kss_back
  import kss_pkg::*;
#(
  parameter int DEPTH      = 64,
  parameter int NUM_STACKS = 4,
  parameter int DATA_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_vld,
  output logic                cmd_take,
  input  cmd_t                cmd,
  output logic                out_empty,
  input  logic                out_pop,
  output logic [VAL_W-1:0]    out_pop_value,
  output logic [STATUS_W-1:0] out_status
);

  localparam int PW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int DW = (DATA_WIDTH < VAL_W) ? DATA_WIDTH : VAL_W;
  localparam logic [PW-1:0] NULL_PTR = PW'(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EXEC  = 3'b010,
    S_POPWR = 3'b100
  } state_t;

  // Storage. Link entries at or above the high-water mark were never
  // written and read as their reset chain value instead.
  logic [PW-1:0] lnk_mem  [DEPTH];
  logic [DW-1:0] data_mem [DEPTH];
  logic [PW-1:0] head_mem [NUM_STACKS];
  logic [NUM_STACKS-1:0] hvld_r;

  state_t        state_r, state_nxt;
  cmd_t          cmd_r;
  logic [PW-1:0] free_head_r, free_head_nxt;
  logic [PW-1:0] hwm_r, hwm_nxt;
  logic [PW-1:0] top_r;
  logic [PW-1:0] head_q_r;
  logic          hvld_q_r;
  logic [PW-1:0] lnk_q_r;
  logic          fresh_q_r;
  logic [PW-1:0] fresh_val_r;
  logic [DW-1:0] data_q_r;

  logic                out_vld_r;
  logic [VAL_W-1:0]    out_value_r;
  logic [STATUS_W-1:0] out_status_r;

  logic [SW+1:0] in_sid_wide;
  logic [SW+1:0] cur_sid_wide;
  logic [SW-1:0] in_idx;
  logic [SW-1:0] cur_idx;
  logic [PW-1:0] head_val;
  logic [PW-1:0] link_val;
  logic          res_ok;

  logic                head_wr_en;
  logic [PW-1:0]       head_wr_data;
  logic                lnk_rd_en;
  logic [PW-1:0]       lnk_rd_ptr;
  logic                lnk_wr_en;
  logic [PW-1:0]       lnk_wr_ptr;
  logic [PW-1:0]       lnk_wr_data;
  logic                data_wr_en;
  logic                res_wr;
  logic [VAL_W-1:0]    res_value;
  logic [STATUS_W-1:0] res_status;
  logic                push_commit;

  assign in_sid_wide  = (SW + 2)'(cmd.sid);
  assign cur_sid_wide = (SW + 2)'(cmd_r.sid);
  assign in_idx       = in_sid_wide[SW-1:0];
  assign cur_idx      = cur_sid_wide[SW-1:0];
  assign head_val     = hvld_q_r ? head_q_r : NULL_PTR;
  assign link_val     = fresh_q_r ? fresh_val_r : lnk_q_r;
  assign res_ok       = !out_vld_r || out_pop;
  assign cmd_take     = state_r[0] && cmd_vld;

  always_comb begin
    state_nxt     = state_r;
    free_head_nxt = free_head_r;
    hwm_nxt       = hwm_r;
    head_wr_en    = 1'b0;
    head_wr_data  = free_head_r;
    lnk_rd_en     = 1'b0;
    lnk_rd_ptr    = free_head_r;
    lnk_wr_en     = 1'b0;
    lnk_wr_ptr    = free_head_r;
    lnk_wr_data   = head_val;
    data_wr_en    = 1'b0;
    res_wr        = 1'b0;
    res_value     = '0;
    res_status    = ST_OK;
    push_commit   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_vld) begin
          state_nxt = S_EXEC;
          if (!cmd.is_pop && free_head_r != NULL_PTR) begin
            lnk_rd_en = 1'b1;
          end
        end
      end
      S_EXEC: begin
        if (!cmd_r.is_pop) begin
          if (res_ok) begin
            res_wr    = 1'b1;
            state_nxt = S_IDLE;
            if (!cmd_r.sid_ok || free_head_r == NULL_PTR) begin
              res_status = ST_OVERFLOW;
            end else begin
              push_commit   = 1'b1;
              lnk_wr_en     = 1'b1;
              head_wr_en    = 1'b1;
              data_wr_en    = 1'b1;
              free_head_nxt = link_val;
              if (free_head_r == hwm_r) begin
                hwm_nxt = hwm_r + PW'(1);
              end
            end
          end
        end else if (!cmd_r.sid_ok || head_val == NULL_PTR) begin
          if (res_ok) begin
            res_wr     = 1'b1;
            res_status = ST_UNDERFLOW;
            state_nxt  = S_IDLE;
          end
        end else begin
          // The top entry's link and data come back from memory next cycle.
          lnk_rd_en  = 1'b1;
          lnk_rd_ptr = head_val;
          state_nxt  = S_POPWR;
        end
      end
      S_POPWR: begin
        if (res_ok) begin
          res_wr        = 1'b1;
          res_value     = VAL_W'(data_q_r);
          head_wr_en    = 1'b1;
          head_wr_data  = link_val;
          lnk_wr_en     = 1'b1;
          lnk_wr_ptr    = top_r;
          lnk_wr_data   = free_head_r;
          free_head_nxt = top_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      cmd_r    <= cmd;
      head_q_r <= head_mem[in_idx];
    end
    if (head_wr_en) begin
      head_mem[cur_idx] <= head_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (lnk_rd_en) begin
      lnk_q_r     <= lnk_mem[lnk_rd_ptr[AW-1:0]];
      data_q_r    <= data_mem[lnk_rd_ptr[AW-1:0]];
      fresh_q_r   <= (lnk_rd_ptr >= hwm_r);
      fresh_val_r <= lnk_rd_ptr + PW'(1);
      top_r       <= lnk_rd_ptr;
    end
    if (lnk_wr_en) begin
      lnk_mem[lnk_wr_ptr[AW-1:0]] <= lnk_wr_data;
    end
    if (data_wr_en) begin
      data_mem[free_head_r[AW-1:0]] <= cmd_r.value[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_head_r <= '0;
      hwm_r       <= '0;
      hvld_r      <= '0;
      hvld_q_r    <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_head_r <= free_head_nxt;
      hwm_r       <= hwm_nxt;
      if (head_wr_en) begin
        hvld_r[cur_idx] <= 1'b1;
      end
      if (cmd_take) begin
        hvld_q_r <= hvld_r[in_idx];
      end
      if (res_wr) begin
        out_vld_r <= 1'b1;
      end else if (out_pop) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_wr) begin
      out_value_r  <= res_value;
      out_status_r <= res_status;
    end
  end

  assign out_empty     = !out_vld_r;
  assign out_pop_value = out_value_r;
  assign out_status    = out_status_r;

  `KSS_ASSERT_IMPL(a_res_slot_free, clk, rst_n, res_wr && out_vld_r, out_pop)
  `KSS_ASSERT_IMPL(a_free_below_hwm, clk, rst_n, free_head_r != NULL_PTR, free_head_r <= hwm_r)
  `KSS_ASSERT_NEXT(a_push_moves_free, clk, rst_n, push_commit, free_head_r != $past(free_head_r))
  `KSS_ASSERT_IMPL(a_take_only_idle, clk, rst_n, state_r != S_IDLE, !res_wr || !cmd_take)

endmodule

// File: hw/rtl/k_stacks_shared_array.sv
// Steps: taking an item reads its stack top; a push or an empty-stack pop then writes
// its result from S_EXEC, any other pop reads the top entry's link and data first and
// writes its result from S_POPWR. A full result slot stalls either write.
// Flow: a new item is taken only in S_IDLE, after the last result; two items queue ahead.
// Reset: synchronous, active low; stack tops use valid bits and the link
// store a high-water mark, so there is no clearing pass and items are taken at once.
module k_stacks_shared_array
  import kss_pkg::*;
#(
  parameter int DEPTH      = 64,
  parameter int NUM_STACKS = 4,
  parameter int DATA_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic                in_mode,
  input  logic [SID_W-1:0]    in_stack_id,
  input  logic [VAL_W-1:0]    in_push_value,
  output logic                out_empty,
  input  logic                out_pop,
  output logic [VAL_W-1:0]    out_pop_value,
  output logic [STATUS_W-1:0] out_status
);

  logic cmd_vld;
  logic cmd_take;
  cmd_t cmd;

  kss_front #(
    .NUM_STACKS(NUM_STACKS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_mode      (in_mode),
    .in_stack_id  (in_stack_id),
    .in_push_value(in_push_value),
    .cmd_vld      (cmd_vld),
    .cmd_take     (cmd_take),
    .cmd          (cmd)
  );

  kss_back #(
    .DEPTH     (DEPTH),
    .NUM_STACKS(NUM_STACKS),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_vld      (cmd_vld),
    .cmd_take     (cmd_take),
    .cmd          (cmd),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_pop_value(out_pop_value),
    .out_status   (out_status)
  );

endmodule

// File: tb/tb_top.sv
module tb_top;
  import kss_pkg::*;

  localparam int DEPTH      = 64;
  localparam int NUM_STACKS = 4;
  localparam int DATA_WIDTH = 32;
  localparam logic [6:0] NIL = 7'(DEPTH);

  typedef struct packed {
    logic [VAL_W-1:0]    value;
    logic [STATUS_W-1:0] status;
  } outcome_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_push = 1'b0;
  logic                in_full;
  logic                in_mode = MODE_PUSH;
  logic [SID_W-1:0]    in_stack_id = '0;
  logic [VAL_W-1:0]    in_push_value = '0;
  logic                out_empty;
  logic                out_pop = 1'b0;
  logic [VAL_W-1:0]    out_pop_value;
  logic [STATUS_W-1:0] out_status;

  // Shadow copy of the linked stores.
  logic [VAL_W-1:0] word_mem [DEPTH];
  logic [6:0]       next_of [DEPTH];
  logic [6:0]       top_of [NUM_STACKS];
  logic [6:0]       free_ptr;

  outcome_t expected_q [$];
  bit       calm = 1'b0;
  int       n_errors = 0;
  int       n_checked = 0;
  int       n_pushes = 0;
  int       n_pops = 0;
  int       n_overflows = 0;
  int       n_underflows = 0;

  k_stacks_shared_array #(
    .DEPTH(DEPTH),
    .NUM_STACKS(NUM_STACKS),
    .DATA_WIDTH(DATA_WIDTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_full(in_full),
    .in_mode(in_mode),
    .in_stack_id(in_stack_id),
    .in_push_value(in_push_value),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_pop_value(out_pop_value),
    .out_status(out_status)
  );

  always #5 clk = ~clk;

  task automatic clear_stack_model();
    for (int i = 0; i < DEPTH; i++) begin
      word_mem[i] = '0;
      next_of[i] = 7'(i + 1);
    end
    next_of[DEPTH-1] = NIL;
    for (int s = 0; s < NUM_STACKS; s++) top_of[s] = NIL;
    free_ptr = '0;
  endtask

  function automatic outcome_t apply_stack_op(logic mode, logic [SID_W-1:0] sid,
                                              logic [VAL_W-1:0] val);
    outcome_t   r;
    logic [6:0] slot;
    r.value = '0;
    r.status = ST_OK;
    if (mode == MODE_PUSH) begin
      slot = free_ptr;
      if (int'(sid) >= NUM_STACKS || slot >= NIL) begin
        r.status = ST_OVERFLOW;
      end else begin
        free_ptr = next_of[slot];
        next_of[slot] = top_of[sid];
        top_of[sid] = slot;
        word_mem[slot] = val;
      end
    end else begin
      slot = (int'(sid) < NUM_STACKS) ? top_of[sid] : NIL;
      if (slot >= NIL) begin
        r.status = ST_UNDERFLOW;
      end else begin
        top_of[sid] = next_of[slot];
        next_of[slot] = free_ptr;
        free_ptr = slot;
        r.value = word_mem[slot];
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
    $display("MISMATCH at %0t: %s got %h expected %h", $time, what, got, want);
    n_errors++;
  endtask

  // Drives one transaction and records what it should produce once accepted.
  task automatic send_op(logic mode, logic [SID_W-1:0] sid, logic [VAL_W-1:0] val);
    outcome_t want;
    @(negedge clk);
    if (!calm && $urandom_range(99) < 10) begin
      in_push = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_push = 1'b1;
    in_mode = mode;
    in_stack_id = sid;
    in_push_value = val;
    do @(posedge clk); while (in_full);
    want = apply_stack_op(mode, sid, val);
    expected_q.push_back(want);
    if (mode == MODE_PUSH) n_pushes++;
    else n_pops++;
    if (want.status == ST_OVERFLOW) n_overflows++;
    if (want.status == ST_UNDERFLOW) n_underflows++;
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(15))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  always @(negedge clk) out_pop <= calm || ($urandom_range(99) >= 10);

  always @(posedge clk) begin : check_results
    outcome_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result with nothing pending, value", out_pop_value, '0);
      end else begin
        want = expected_q.pop_front();
        if (out_pop_value !== want.value)
          report_mismatch("pop_value", out_pop_value, want.value);
        if (out_status !== want.status)
          report_mismatch("status", 32'(out_status), 32'(want.status));
        n_checked++;
      end
    end
  end

  task automatic test_directed();
    for (int s = 0; s < NUM_STACKS; s++) send_op(MODE_POP, SID_W'(s), '0);
    send_op(MODE_PUSH, 2'd0, 32'h8000_0000);
    send_op(MODE_PUSH, 2'd1, 32'h7FFF_FFFF);
    send_op(MODE_PUSH, 2'd2, 32'hFFFF_FFFF);
    send_op(MODE_PUSH, 2'd3, 32'h0000_0000);
    send_op(MODE_PUSH, 2'd1, 32'hAAAA_AAAA);
    send_op(MODE_PUSH, 2'd1, 32'h5555_5555);
    // Last in, first out on one stack, then one pop too many.
    repeat (4) send_op(MODE_POP, 2'd1, 32'hFFFF_FFFF);
    send_op(MODE_POP, 2'd0, '0);
    send_op(MODE_POP, 2'd2, '0);
    send_op(MODE_POP, 2'd3, '0);
    send_op(MODE_POP, 2'd0, '0);
    // The entry just freed is taken again from the head of the free list.
    send_op(MODE_PUSH, 2'd2, 32'h1234_5678);
    send_op(MODE_POP, 2'd2, '0);
  endtask

  task automatic test_fill_overflow();
    while (free_ptr != NIL) send_op(MODE_PUSH, SID_W'($urandom_range(3)), pick_value());
    for (int s = 0; s < NUM_STACKS; s++) send_op(MODE_PUSH, SID_W'(s), pick_value());
    for (int s = 0; s < NUM_STACKS; s++) begin
      while (top_of[s] != NIL) send_op(MODE_POP, SID_W'(s), $urandom);
      send_op(MODE_POP, SID_W'(s), $urandom);
    end
  endtask

  task automatic test_random();
    int push_pct [13] = '{85, 20, 50, 90, 10, 50, 60, 40, 85, 15, 50, 70, 30};
    for (int p = 0; p < 13; p++) begin
      calm = (p == 6);
      for (int i = 0; i < 120; i++) begin
        if ($urandom_range(99) < push_pct[p])
          send_op(MODE_PUSH, SID_W'($urandom_range(3)), pick_value());
        else
          send_op(MODE_POP, SID_W'($urandom_range(3)), $urandom);
      end
    end
    calm = 1'b0;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_push = 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    clear_stack_model();
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_fill_overflow();
    test_random();
    drain_results();
    $display("Covered %0d pushes and %0d pops on %0d stacks, %0d results checked.",
             n_pushes, n_pops, NUM_STACKS, n_checked);
    $display("Overflows seen: %0d, underflows seen: %0d, mismatches: %0d.",
             n_overflows, n_underflows, n_errors);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results still pending.", expected_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
